[rtl/dra_pkg.sv]
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the dirty rectangle accumulator
// Item kinds, register indexes, box state and screen dimension clamp.
// ----------------------------------------------------------------------------
package dra_pkg;

  // Largest usable screen dimension is 2**DIM_BITS pixels
  localparam int DIM_BITS  = 14;
  localparam int DIM_LIMIT = 1 << DIM_BITS;

  localparam int COORD_W = 15;   // box coordinates and screen registers
  localparam int IN_W    = 16;   // signed rect fields
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int IN_TDATA_W  = 4 * IN_W;                          // 64
  localparam int OUT_DATA_W  = 4 * COORD_W;                       // 60
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;        // 64

  typedef enum logic [KIND_W-1:0] {
    KIND_RECT  = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_READY = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   dirty;
    logic   whole;
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } box_t;

  typedef struct packed {
    logic   ready;
    coord_t width;
    coord_t height;
  } screen_t;

  // Saturate a screen dimension to 2**DIM_BITS
  function automatic coord_t eff_dim(input coord_t dim);
    logic [COORD_W+1:0] lim;
    lim = (COORD_W+2)'(DIM_LIMIT);
    if ({2'b00, dim} > lim) begin
      eff_dim = lim[COORD_W-1:0];
    end else begin
      eff_dim = dim;
    end
  endfunction

endpackage

[rtl/dirty_rect_accumulator_core.sv]
// ----------------------------------------------------------------------------
// dirty_rect_accumulator_core: dirty region bounding box tracker
// Path: input register, then box update and result register. Throughput:
//   one beat per cycle while out_tready does not hold the result slot; the
//   combinational box update between the input register and the box state
//   register closes the loop that sets this rate.
// Reset: synchronous active-low rst_n clears box, config registers and valids.
// ----------------------------------------------------------------------------
module dirty_rect_accumulator_core (
  input  logic                             clk,
  input  logic                             rst_n,

  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic [dra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dra_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: rect_x[15:0], rect_y[31:16], rect_width[47:32],
  //   rect_height[63:48]
  input  logic [dra_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: kind[1:0]
  input  logic [dra_pkg::KIND_W-1:0]       in_tuser,

  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: damage_x[14:0], damage_y[29:15], damage_width[44:30],
  //   damage_height[59:45], zero pad[63:60]
  output logic [dra_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser, low bit up: damage_any[0], damage_full[1]
  output logic [1:0]                       out_tuser
);
  import dra_pkg::*;

  // Configuration registers
  screen_t scr_r;

  // Input register stage
  logic                  s1_vld_r;
  logic [KIND_W-1:0]     s1_kind_r;
  logic [IN_TDATA_W-1:0] s1_data_r;

  // Box state and result register
  box_t   box_r, box_nxt;
  logic   out_vld_r;
  logic   any_r, any_nxt;
  logic   full_r, full_nxt;
  coord_t dx_r, dy_r, dw_r, dh_r;
  coord_t dx_nxt, dy_nxt, dw_nxt, dh_nxt;

  logic   advance;

  // Move the held beat into the result register whenever that slot frees up
  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISPLAY_READY: scr_r.ready  <= cfg_wdata[0];
        REG_SCREEN_WIDTH:  scr_r.width  <= cfg_wdata[COORD_W-1:0];
        REG_SCREEN_HEIGHT: scr_r.height <= cfg_wdata[COORD_W-1:0];
        default:           scr_r        <= scr_r;   // unmapped index, drop
      endcase
    end
  end

  // Input register: hold while the downstream slot is busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  dra_step u_step (
    .scr         (scr_r),
    .kind        (s1_kind_r),
    .rect_x      (s1_data_r[IN_W-1:0]),
    .rect_y      (s1_data_r[2*IN_W-1:IN_W]),
    .rect_width  (s1_data_r[3*IN_W-1:2*IN_W]),
    .rect_height (s1_data_r[4*IN_W-1:3*IN_W]),
    .box_cur     (box_r),
    .box_nxt     (box_nxt)
  );

  // Report the box as it stands after this item; zeros when none is valid
  always_comb begin
    any_nxt  = scr_r.ready && box_nxt.dirty;
    full_nxt = 1'b0;
    dx_nxt   = '0;
    dy_nxt   = '0;
    dw_nxt   = '0;
    dh_nxt   = '0;
    if (any_nxt) begin
      full_nxt = box_nxt.whole;
      dx_nxt   = box_nxt.left;
      dy_nxt   = box_nxt.top;
      dw_nxt   = (box_nxt.right > box_nxt.left) ? box_nxt.right - box_nxt.left : '0;
      dh_nxt   = (box_nxt.bottom > box_nxt.top) ? box_nxt.bottom - box_nxt.top : '0;
    end
  end

  // Advance the box state only when the item moves into the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        box_r <= box_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      any_r  <= any_nxt;
      full_r <= full_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      dw_r   <= dw_nxt;
      dh_r   <= dh_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {full_r, any_r};
  assign out_tdata  = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}}, dh_r, dw_r, dy_r, dx_r};

endmodule

[rtl/dra_step.sv]
// ----------------------------------------------------------------------------
// dra_step: box update for one item
// Clips a rect to the screen and unions it into the box, or applies a
// full or clear item. Pure combinational.
// ----------------------------------------------------------------------------
module dra_step (
  input  dra_pkg::screen_t            scr,
  input  logic [dra_pkg::KIND_W-1:0]  kind,
  input  logic [dra_pkg::IN_W-1:0]    rect_x,
  input  logic [dra_pkg::IN_W-1:0]    rect_y,
  input  logic [dra_pkg::IN_W-1:0]    rect_width,
  input  logic [dra_pkg::IN_W-1:0]    rect_height,
  input  dra_pkg::box_t               box_cur,
  output dra_pkg::box_t               box_nxt
);
  import dra_pkg::*;

  localparam int SW = IN_W + 2;   // room for origin plus size and sign

  coord_t          sw, sh;
  logic signed [SW-1:0] x0, y0, x1, y1, sw_s, sh_s;
  logic signed [SW-1:0] cx0, cy0, cx1, cy1;
  logic            drop;
  coord_t          nx0, ny0, nx1, ny1;
  box_t            box_add;

  assign sw   = eff_dim(scr.width);
  assign sh   = eff_dim(scr.height);
  assign sw_s = $signed({{(SW-COORD_W){1'b0}}, sw});
  assign sh_s = $signed({{(SW-COORD_W){1'b0}}, sh});

  assign x0 = $signed({{(SW-IN_W){rect_x[IN_W-1]}}, rect_x});
  assign y0 = $signed({{(SW-IN_W){rect_y[IN_W-1]}}, rect_y});
  assign x1 = x0 + $signed({{(SW-IN_W){rect_width[IN_W-1]}}, rect_width});
  assign y1 = y0 + $signed({{(SW-IN_W){rect_height[IN_W-1]}}, rect_height});

  // Clip to the screen
  assign cx0 = (x0 < 0)    ? '0   : x0;
  assign cy0 = (y0 < 0)    ? '0   : y0;
  assign cx1 = (x1 > sw_s) ? sw_s : x1;
  assign cy1 = (y1 > sh_s) ? sh_s : y1;

  // Drop non-positive sizes, rects off screen and empty clip results
  assign drop = rect_width[IN_W-1]  || (rect_width  == '0) ||
                rect_height[IN_W-1] || (rect_height == '0) ||
                (x1 <= 0) || (y1 <= 0) || (x0 >= sw_s) || (y0 >= sh_s) ||
                (cx1 <= cx0) || (cy1 <= cy0);

  assign nx0 = cx0[COORD_W-1:0];
  assign ny0 = cy0[COORD_W-1:0];
  assign nx1 = cx1[COORD_W-1:0];
  assign ny1 = cy1[COORD_W-1:0];

  always_comb begin
    box_add = box_cur;
    if (drop) begin
      box_add = box_cur;
    end else if (!box_cur.dirty) begin
      box_add.dirty  = 1'b1;
      box_add.whole  = 1'b0;
      box_add.left   = nx0;
      box_add.top    = ny0;
      box_add.right  = nx1;
      box_add.bottom = ny1;
    end else if (!box_cur.whole) begin
      box_add.left   = (nx0 < box_cur.left)   ? nx0 : box_cur.left;
      box_add.top    = (ny0 < box_cur.top)    ? ny0 : box_cur.top;
      box_add.right  = (nx1 > box_cur.right)  ? nx1 : box_cur.right;
      box_add.bottom = (ny1 > box_cur.bottom) ? ny1 : box_cur.bottom;
    end
  end

  always_comb begin
    box_nxt = box_cur;
    unique case (kind_t'(kind))
      KIND_RECT: begin
        if (scr.ready) begin
          box_nxt = box_add;
        end
      end
      KIND_FULL: begin
        if (scr.ready) begin
          box_nxt.dirty  = 1'b1;
          box_nxt.whole  = 1'b1;
          box_nxt.left   = '0;
          box_nxt.top    = '0;
          box_nxt.right  = sw;
          box_nxt.bottom = sh;
        end
      end
      KIND_CLEAR: begin
        box_nxt = '0;
      end
      default: begin
        box_nxt = box_cur;
      end
    endcase
  end

endmodule

[tb/dirty_rect_accumulator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_rect_accumulator_core_tb: self-checking bench for the damage tracker
// Streams add/full/clear/unused commands into the core under several screen
// settings and compares every result beat with a bounding-box predictor kept
// in the bench, with random gaps on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module dirty_rect_accumulator_core_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;  // no command, still reports
  localparam int IDLE_SETTLE    = 8;          // slack after the last result beat
  localparam int HOLD_CYCLES    = 80;         // long output hold-off
  localparam int WATCHDOG_LIMIT = 1000;       // cycles with no beat on either side

  // One expected result beat, field by field
  typedef struct packed {
    logic        any;
    logic        full;
    logic [14:0] x;
    logic [14:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } damage_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_wr_en = 1'b0;
  logic [dra_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [dra_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [dra_pkg::IN_TDATA_W-1:0]      in_tdata = '0;
  logic [dra_pkg::KIND_W-1:0]          in_tuser = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [dra_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic [1:0]                          out_tuser;

  // Bench copy of the registers and the dirty box
  bit          disp_ready = 1'b0;
  logic [14:0] scr_width  = '0;
  logic [14:0] scr_height = '0;
  bit          box_dirty  = 1'b0;
  bit          box_whole  = 1'b0;
  logic [14:0] box_lft = '0;
  logic [14:0] box_top = '0;
  logic [14:0] box_rgt = '0;
  logic [14:0] box_bot = '0;

  damage_t damage_q[$];   // expected result beats, oldest first
  damage_t want;
  int      err_cnt = 0;

  // Idle controls shared between the stimulus and the result side
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_reqs  = 0;     // bumped by a test to request a long hold-off
  int hold_seen  = 0;
  int rx_hold    = 0;
  int rx_stall   = 0;
  int quiet_cycles = 0;

  dirty_rect_accumulator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // rect_x, rect_y, rect_width, rect_height
    .in_tuser   (in_tuser),     // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // damage_x, damage_y, damage_width, damage_height
    .out_tuser  (out_tuser)     // damage_any, damage_full
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a screen dimension to the largest one the core supports
  function automatic int dim_clamp(input logic [14:0] dim);
    return (int'(dim) > dra_pkg::DIM_LIMIT) ? dra_pkg::DIM_LIMIT : int'(dim);
  endfunction

  // Apply one accepted command to the bench box and return the result beat
  function automatic damage_t predict_damage(input logic [1:0] kind,
                                             input logic signed [15:0] rx, ry,
                                             input logic signed [15:0] rw, rh);
    int      sw, sh, x0, y0, x1, y1;
    damage_t d;
    sw = dim_clamp(scr_width);
    sh = dim_clamp(scr_height);
    x0 = rx;
    y0 = ry;
    x1 = x0 + rw;
    y1 = y0 + rh;
    case (kind)
      dra_pkg::KIND_RECT: begin
        // Drop empty, off-screen and clipped-away rects
        if (disp_ready && rw > 0 && rh > 0 && x1 > 0 && y1 > 0 &&
            x0 < sw && y0 < sh) begin
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > sw) x1 = sw;
          if (y1 > sh) y1 = sh;
          if (x1 > x0 && y1 > y0) begin
            if (!box_dirty) begin
              box_dirty = 1'b1;
              box_whole = 1'b0;
              box_lft = x0[14:0];
              box_top = y0[14:0];
              box_rgt = x1[14:0];
              box_bot = y1[14:0];
            end else if (!box_whole) begin
              if (x0 < int'(box_lft)) box_lft = x0[14:0];
              if (y0 < int'(box_top)) box_top = y0[14:0];
              if (x1 > int'(box_rgt)) box_rgt = x1[14:0];
              if (y1 > int'(box_bot)) box_bot = y1[14:0];
            end
          end
        end
      end
      dra_pkg::KIND_FULL: begin
        if (disp_ready) begin
          box_dirty = 1'b1;
          box_whole = 1'b1;
          box_lft = '0;
          box_top = '0;
          box_rgt = sw[14:0];
          box_bot = sh[14:0];
        end
      end
      dra_pkg::KIND_CLEAR: begin
        // Clear acts whether or not the display is ready
        box_dirty = 1'b0;
        box_whole = 1'b0;
        box_lft = '0;
        box_top = '0;
        box_rgt = '0;
        box_bot = '0;
      end
      default: ;
    endcase
    d = '0;
    if (disp_ready && box_dirty) begin
      d.any  = 1'b1;
      d.full = box_whole;
      d.x    = box_lft;
      d.y    = box_top;
      d.w    = (box_rgt > box_lft) ? box_rgt - box_lft : '0;
      d.h    = (box_bot > box_top) ? box_bot - box_top : '0;
    end
    return d;
  endfunction

  // Offer one command beat, hold it until accepted, then log its result
  task automatic send_item(input logic [1:0] kind, input int rx, ry, rw, rh);
    logic signed [15:0] fx, fy, fw, fh;
    fx = rx[15:0];
    fy = ry[15:0];
    fw = rw[15:0];
    fh = rh[15:0];
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fh, fw, fy, fx};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    damage_q.push_back(predict_damage(kind, fx, fy, fw, fh));
  endtask

  // Drop valid and wait until every expected beat has come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (damage_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write all three registers while the core is idle
  task automatic program_display(input bit ready, input int w, input int h);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= dra_pkg::REG_DISPLAY_READY;
    cfg_wdata <= {14'd0, ready};
    @(posedge clk);
    disp_ready = ready;
    cfg_index <= dra_pkg::REG_SCREEN_WIDTH;
    cfg_wdata <= w[14:0];
    @(posedge clk);
    scr_width = w[14:0];
    cfg_index <= dra_pkg::REG_SCREEN_HEIGHT;
    cfg_wdata <= h[14:0];
    @(posedge clk);
    scr_height = h[14:0];
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly rects around the visible area, some full/clear/unused, some noise
  task automatic send_random_item();
    int         sw, sh, sel, x, y, w, h;
    logic [1:0] kind;
    sw  = dim_clamp(scr_width);
    sh  = dim_clamp(scr_height);
    x   = int'($urandom_range(0, sw + sw / 2 + 8)) - sw / 4 - 4;
    y   = int'($urandom_range(0, sh + sh / 2 + 8)) - sh / 4 - 4;
    w   = $urandom_range(1, sw / 2 + 4);
    h   = $urandom_range(1, sh / 2 + 4);
    // Noise: any 16-bit pattern, negative sizes and far origins included
    if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 65535);
    sel = $urandom_range(0, 99);
    if (sel < 78)      kind = dra_pkg::KIND_RECT;
    else if (sel < 84) kind = dra_pkg::KIND_FULL;
    else if (sel < 93) kind = dra_pkg::KIND_CLEAR;
    else               kind = KIND_UNUSED;
    send_item(kind, x, y, w, h);
  endtask

  // Reset values: not ready, zero screen; rects and full do nothing
  task automatic test_not_ready();
    send_item(dra_pkg::KIND_RECT, 10, 10, 20, 20);
    send_item(dra_pkg::KIND_FULL, 0, 0, 0, 0);
    send_item(KIND_UNUSED, 1, 2, 3, 4);
    program_display(1'b0, 640, 480);
    send_item(dra_pkg::KIND_FULL, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_RECT, 0, 0, 640, 480);
    send_item(dra_pkg::KIND_CLEAR, 0, 0, 0, 0);
  endtask

  // Drop rules, clipping, union and the full-box lockout
  task automatic test_rect_rules();
    program_display(1'b1, 640, 480);
    send_item(dra_pkg::KIND_RECT, 10, 10, 0, 5);           // zero width
    send_item(dra_pkg::KIND_RECT, 10, 10, 5, -1);          // negative height
    send_item(dra_pkg::KIND_RECT, -100, 10, 50, 20);       // wholly left
    send_item(dra_pkg::KIND_RECT, 10, 480, 5, 5);          // wholly below
    send_item(dra_pkg::KIND_RECT, -10, 10, 10, 10);        // right edge at zero
    send_item(dra_pkg::KIND_RECT, -20, -30, 100, 100);     // starts box, clipped
    send_item(dra_pkg::KIND_RECT, 600, 400, 100, 200);     // union, clipped
    send_item(dra_pkg::KIND_RECT, 32767, 32767, 32767, 32767);
    send_item(dra_pkg::KIND_RECT, -32768, -32768, 32767, 32767);
    send_item(KIND_UNUSED, 5, 5, 5, 5);
    send_item(dra_pkg::KIND_FULL, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_RECT, 5, 5, 5, 5);             // ignored while full
    send_item(dra_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_RECT, 100, 200, 1, 1);
  endtask

  // Oversized screen saturates, zero screen, resize keeps the stored box
  task automatic test_screen_edges();
    program_display(1'b1, 32767, 16385);
    send_item(dra_pkg::KIND_FULL, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_RECT, -16000, 16000, 32767, 1000);
    program_display(1'b1, 0, 0);
    send_item(dra_pkg::KIND_RECT, 0, 0, 10, 10);           // dropped, box kept
    send_item(dra_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_item(dra_pkg::KIND_FULL, 0, 0, 0, 0);             // full, size zero
  endtask

  // Random commands under a spread of screen settings
  task automatic test_random();
    int rdy[7] = '{1, 1, 1, 1, 0, 1, 1};
    int wid[7] = '{640, 16384, 32767, 1, 320, 0, 0};
    int hgt[7] = '{480, 16384, 20000, 1, 200, 0, 0};
    wid[6] = $urandom_range(0, 32767);
    hgt[6] = $urandom_range(0, 32767);
    for (int p = 0; p < 7; p++) begin
      program_display(rdy[p][0], wid[p], hgt[p]);
      repeat (70) send_random_item();
    end
  endtask

  // Hold the output off while the input keeps offering, so the core stalls
  task automatic test_backpressure();
    program_display(1'b1, 800, 600);
    tx_idle_en = 1'b0;
    hold_reqs++;
    repeat (40) send_random_item();
    tx_idle_en = 1'b1;
  endtask

  // Pause the input until the core has drained, then resume
  task automatic test_drain_pause();
    repeat (20) send_random_item();
    wait_idle();
    repeat (20) send_random_item();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_display(1'b1, 1920, 1080);
    repeat (80) send_random_item();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_rect_rules();
    test_screen_edges();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    wait_idle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: check each beat against the oldest expectation, then
  // choose tready for the next cycle (long hold, short bursts, or ready)
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (damage_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, actual tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = damage_q.pop_front();
        check_field("damage_any", want.any, out_tuser[0]);
        check_field("damage_full", want.full, out_tuser[1]);
        check_field("damage_x", want.x, out_tdata[14:0]);
        check_field("damage_y", want.y, out_tdata[29:15]);
        check_field("damage_width", want.w, out_tdata[44:30]);
        check_field("damage_height", want.h, out_tdata[59:45]);
        check_field("tdata pad", 0, out_tdata[63:60]);
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      rx_hold   = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 damage_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
